// ===== hw/rtl/tvi_pkg.sv =====
// ----------------------------------------------------------------------------
// tvi_pkg - shared types and constants of the trilinear vector interpolator
// Request and response structs, stage control and fixed field widths.
// ----------------------------------------------------------------------------
package tvi_pkg;

    localparam int POS_W    = 24;
    localparam int VAL_W    = 32;
    localparam int SUM_W    = 48;
    localparam int CORNERS  = 8;
    localparam int CORNER_W = 3;

    // corner number bits: set selects the upper voxel on that axis
    localparam int CORNER_BIT_EAST  = 0;
    localparam int CORNER_BIT_NORTH = 1;
    localparam int CORNER_BIT_TOP   = 2;

    localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(CORNERS - 1);

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_OUTSIDE = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0]        pos_east;
        logic [POS_W-1:0]        pos_north;
        logic [POS_W-1:0]        pos_top;
        logic [CORNER_W-1:0]     corner_index;
        logic signed [VAL_W-1:0] comp_x_value;
        logic signed [VAL_W-1:0] comp_y_value;
        logic signed [VAL_W-1:0] comp_z_value;
        logic                    value_is_null;
        logic                    point_outside;
    } t_in_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] vel_east;
        logic signed [VAL_W-1:0] vel_north;
        logic signed [VAL_W-1:0] vel_up;
        logic                    status;
    } t_out_req;

    // control that travels alongside one corner through the pipeline
    typedef struct packed {
        logic valid;
        logic last;
        logic outside;
    } t_stage_ctl;

    typedef struct packed {
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic signed [VAL_W-1:0] z;
    } t_vec;

endpackage

// ===== hw/rtl/tvi_weight.sv =====
// ----------------------------------------------------------------------------
// tvi_weight - corner weight pipeline
// Three stages: axis weights, east*north product, product times top weight.
// ----------------------------------------------------------------------------
module tvi_weight #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_advance,
    input  logic                   i_valid,
    input  tvi_pkg::t_in_req       i_req,
    output tvi_pkg::t_stage_ctl    o_ctl,
    output tvi_pkg::t_vec          o_vals,
    output logic [FRAC_BITS:0]     o_weight
);
    import tvi_pkg::*;

    localparam int W = FRAC_BITS + 1;
    localparam logic [W-1:0] ONE  = W'(1) << FRAC_BITS;
    localparam logic [W-1:0] HALF = W'(1) << (FRAC_BITS - 1);

    function automatic logic [W-1:0] f_axis(logic [POS_W-1:0] pos, logic upper);
        logic [FRAC_BITS-1:0] frac;
        frac = pos[FRAC_BITS-1:0] - HALF[FRAC_BITS-1:0];
        return upper ? {1'b0, frac} : ONE - {1'b0, frac};
    endfunction

    t_stage_ctl r_a_ctl, r_b_ctl, r_c_ctl;
    t_vec       r_a_vals, r_b_vals, r_c_vals;
    logic [W-1:0] r_ae, r_an, r_at, r_b_at, r_w2, r_w;
    t_vec       n_vals;
    logic [2*W-1:0] prod_en, prod_top;

    always_comb begin
        n_vals.x = i_req.value_is_null ? '0 : i_req.comp_x_value;
        n_vals.y = i_req.value_is_null ? '0 : i_req.comp_y_value;
        n_vals.z = i_req.value_is_null ? '0 : i_req.comp_z_value;
    end

    assign prod_en  = r_ae * r_an + (2*W)'(HALF);
    assign prod_top = r_w2 * r_b_at + (2*W)'(HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
            r_c_ctl <= '0;
        end else if (i_advance) begin
            r_a_ctl.valid   <= i_valid;
            r_a_ctl.last    <= i_req.corner_index == LAST_CORNER;
            r_a_ctl.outside <= i_req.point_outside;
            r_b_ctl         <= r_a_ctl;
            r_c_ctl         <= r_b_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_a_vals <= n_vals;
            r_ae     <= f_axis(i_req.pos_east,  i_req.corner_index[CORNER_BIT_EAST]);
            r_an     <= f_axis(i_req.pos_north, i_req.corner_index[CORNER_BIT_NORTH]);
            r_at     <= f_axis(i_req.pos_top,   i_req.corner_index[CORNER_BIT_TOP]);
            r_b_vals <= r_a_vals;
            r_w2     <= prod_en[FRAC_BITS +: W];
            r_b_at   <= r_at;
            r_c_vals <= r_b_vals;
            r_w      <= prod_top[FRAC_BITS +: W];
        end
    end

    assign o_ctl    = r_c_ctl;
    assign o_vals   = r_c_vals;
    assign o_weight = r_w;

endmodule

// ===== hw/rtl/tvi_lane.sv =====
// ----------------------------------------------------------------------------
// tvi_lane - one component lane
// Registered value*weight product, rounding and the 48-bit accumulator.
// ----------------------------------------------------------------------------
module tvi_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  tvi_pkg::t_stage_ctl           i_ctl,
    input  logic signed [tvi_pkg::VAL_W-1:0] i_value,
    input  logic [FRAC_BITS:0]            i_weight,
    output tvi_pkg::t_stage_ctl           o_ctl,
    output logic [tvi_pkg::SUM_W-1:0]     o_sum_next
);
    import tvi_pkg::*;

    localparam int PROD_W = VAL_W + FRAC_BITS + 2;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

    t_stage_ctl               r_ctl;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] prod, rnd, shifted;
    logic [SUM_W-1:0]         r_sum, n_sum;

    assign prod    = i_value * $signed({1'b0, i_weight});
    assign rnd     = r_prod + $signed(HALF);
    assign shifted = rnd >>> FRAC_BITS;
    assign n_sum   = r_sum + SUM_W'(shifted);

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_prod <= prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
            r_sum <= '0;
        end else if (i_advance) begin
            r_ctl <= i_ctl;
            // clear after the last corner so the next set starts from zero
            if (r_ctl.valid) begin
                r_sum <= r_ctl.last ? '0 : n_sum;
            end
        end
    end

    assign o_ctl      = r_ctl;
    assign o_sum_next = n_sum;

endmodule

// ===== hw/rtl/tvi_merge.sv =====
// ----------------------------------------------------------------------------
// tvi_merge - lane merge and response register
// Tracks the outside flag, saturates the lane sums and holds the response.
// ----------------------------------------------------------------------------
module tvi_merge (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tvi_pkg::t_stage_ctl        i_ctl,
    input  logic [tvi_pkg::SUM_W-1:0]  i_sum_x,
    input  logic [tvi_pkg::SUM_W-1:0]  i_sum_y,
    input  logic [tvi_pkg::SUM_W-1:0]  i_sum_z,
    input  logic                       i_stall,
    output logic                       o_advance,
    output logic                       o_valid,
    output tvi_pkg::t_out_req          o_rsp
);
    import tvi_pkg::*;

    function automatic logic [VAL_W-1:0] f_sat(logic [SUM_W-1:0] sum);
        logic [VAL_W-1:0] res;
        if (sum[SUM_W-1:VAL_W-1] == '0 || sum[SUM_W-1:VAL_W-1] == '1) begin
            res = sum[VAL_W-1:0];
        end else begin
            res = sum[SUM_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
        return res;
    endfunction

    logic     r_outside, r_valid, seen, emit;
    t_out_req r_rsp;

    // hold the pipeline only when a finished set meets a stalled full register
    assign o_advance = !(i_ctl.valid && i_ctl.last && r_valid && i_stall);
    assign seen      = r_outside | i_ctl.outside;
    assign emit      = o_advance && i_ctl.valid && i_ctl.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outside <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (o_advance && i_ctl.valid) begin
                r_outside <= i_ctl.last ? 1'b0 : seen;
            end
            if (emit) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            if (seen) begin
                r_rsp.vel_east  <= '0;
                r_rsp.vel_north <= '0;
                r_rsp.vel_up    <= '0;
                r_rsp.status    <= STATUS_OUTSIDE;
            end else begin
                r_rsp.vel_east  <= f_sat(i_sum_x);
                r_rsp.vel_north <= f_sat(i_sum_y);
                r_rsp.vel_up    <= f_sat(i_sum_z);
                r_rsp.status    <= STATUS_OK;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ===== hw/rtl/trilinear_vector_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// trilinear_vector_interpolator_core - trilinear vector field interpolator
// Accumulates the weighted corner requests of a set, up to the last corner, into one Q16.16 vector.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall / i_req): one request per cube corner,
//   each with the point position, corner number and the three components.
//   A request is taken at a clock edge with i_valid high and o_stall low.
//   Output channel (o_valid / i_stall / o_rsp): one response per set, issued
//   for the request whose corner number is the last corner.
//   Throughput: one request per cycle while o_stall is low. Each request passes three weight
//   stages and one product stage in each of the three component lanes; the
//   last corner's sums go straight into the response register behind o_valid.
//   Stall: a waiting response does not block new corners; only when the
//   next set's last corner reaches the accumulators while the response is
//   still stalled does the pipeline hold, and o_stall rises.
//   Reset (synchronous, active low): drops all requests in flight, clears
//   the accumulators and the outside flag, and empties the response register.
// ----------------------------------------------------------------------------
module trilinear_vector_interpolator_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  tvi_pkg::t_in_req      i_req,
    output logic                  o_valid,
    input  logic                  i_stall,
    output tvi_pkg::t_out_req     o_rsp
);
    import tvi_pkg::*;

    logic               advance;
    t_stage_ctl         w_ctl, lane_ctl;
    t_vec               w_vals;
    logic [FRAC_BITS:0] w_weight;
    logic [SUM_W-1:0]   sum_x, sum_y, sum_z;

    // one advance for the whole pipeline, driven by the merge stage
    assign o_stall = !advance;

    tvi_weight #(.FRAC_BITS(FRAC_BITS)) u_weight (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_valid   (i_valid),
        .i_req     (i_req),
        .o_ctl     (w_ctl),
        .o_vals    (w_vals),
        .o_weight  (w_weight)
    );

    // three component lanes share the weight; lane x carries the control
    tvi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_ctl      (w_ctl),
        .i_value    (w_vals.x),
        .i_weight   (w_weight),
        .o_ctl      (lane_ctl),
        .o_sum_next (sum_x)
    );

    tvi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_ctl      (w_ctl),
        .i_value    (w_vals.y),
        .i_weight   (w_weight),
        .o_ctl      (),
        .o_sum_next (sum_y)
    );

    tvi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_ctl      (w_ctl),
        .i_value    (w_vals.z),
        .i_weight   (w_weight),
        .o_ctl      (),
        .o_sum_next (sum_z)
    );

    // saturate, apply the outside status and register the response
    tvi_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (lane_ctl),
        .i_sum_x   (sum_x),
        .i_sum_y   (sum_y),
        .i_sum_z   (sum_z),
        .i_stall   (i_stall),
        .o_advance (advance),
        .o_valid   (o_valid),
        .o_rsp     (o_rsp)
    );

endmodule

// ===== dv/trilinear_vector_interpolator_core_tb.sv =====
// ----------------------------------------------------------------------------
// trilinear_vector_interpolator_core_tb - self-checking bench of the interpolator
// Streams corner requests through the core, predicts each interpolated vector
// in the bench and compares every response field by field, under random idle
// cycles on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module trilinear_vector_interpolator_core_tb;

    import tvi_pkg::*;

    localparam int     FRAC      = 16;
    localparam longint ONE       = longint'(1) << FRAC;
    localparam longint HALF      = ONE >> 1;
    localparam int     RAND_REQS = 1300;
    localparam int     IDLE_PCT  = 19;
    localparam int     TAIL_CYC  = 20;

    localparam logic [CORNER_W-1:0] CORNER_ORIGIN = '0;
    localparam logic [CORNER_W-1:0] CORNER_EAST   = CORNER_W'(1 << CORNER_BIT_EAST);
    localparam logic [CORNER_W-1:0] CORNER_NORTH  = CORNER_W'(1 << CORNER_BIT_NORTH);
    localparam logic [CORNER_W-1:0] CORNER_TOP    = CORNER_W'(1 << CORNER_BIT_TOP);

    localparam logic [POS_W-1:0] POS_CENTER = 24'h008000;
    localparam logic [POS_W-1:0] POS_MAX    = 24'hFFFFFF;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFFFFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

    typedef struct {
        t_in_req  req;
        bit       typed;
        t_out_req rsp;
    } t_corner_row;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     i_stall = 1'b0;
    t_in_req  i_req   = '0;
    logic     o_stall;
    logic     o_valid;
    t_out_req o_rsp;

    // predictor state: Q32.16 sums that wrap at 48 bits, sticky outside flag
    logic [SUM_W-1:0] acc_east  = '0;
    logic [SUM_W-1:0] acc_north = '0;
    logic [SUM_W-1:0] acc_up    = '0;
    logic             outside_flag = 1'b0;

    t_out_req    pending_vectors[$];
    t_corner_row directed_rows[$];

    bit          idle_on = 1'b1;
    int unsigned fail_count   = 0;
    int unsigned req_count    = 0;
    int unsigned vec_count    = 0;
    int unsigned outside_vecs = 0;
    int unsigned null_corners = 0;

    trilinear_vector_interpolator_core #(
        .FRAC_BITS(FRAC)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req  (i_req),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_rsp  (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // weight on one axis: frac(pos - 0.5) for the upper voxel, one minus it else
    function automatic longint axis_wt(input logic [POS_W-1:0] pos, input logic upper);
        longint f;
        f = (longint'(pos) - HALF) & (ONE - 1);
        return upper ? f : ONE - f;
    endfunction

    // round half up, floor toward minus infinity
    function automatic longint weigh_val(input logic signed [VAL_W-1:0] v, input longint w);
        longint p;
        p = longint'(v) * w + HALF;
        return p >>> FRAC;
    endfunction

    function automatic logic signed [VAL_W-1:0] sat32(input logic [SUM_W-1:0] s);
        longint sx;
        sx = longint'(signed'(s));
        if (sx > 64'sd2147483647)
            return VAL_MAX;
        if (sx < -64'sd2147483648)
            return VAL_MIN;
        return sx[VAL_W-1:0];
    endfunction

    // fold one corner into the sums; return 1 with the vector on the last corner
    function automatic bit interp_corner(input t_in_req r, output t_out_req rsp);
        longint ae, an, at, w2, w, c;
        ae = axis_wt(r.pos_east,  r.corner_index[CORNER_BIT_EAST]);
        an = axis_wt(r.pos_north, r.corner_index[CORNER_BIT_NORTH]);
        at = axis_wt(r.pos_top,   r.corner_index[CORNER_BIT_TOP]);
        w2 = (ae * an + HALF) >> FRAC;
        w  = (w2 * at + HALF) >> FRAC;
        rsp = '0;
        if (!r.value_is_null) begin
            c = weigh_val(r.comp_x_value, w);
            acc_east = acc_east + c[SUM_W-1:0];
            c = weigh_val(r.comp_y_value, w);
            acc_north = acc_north + c[SUM_W-1:0];
            c = weigh_val(r.comp_z_value, w);
            acc_up = acc_up + c[SUM_W-1:0];
        end
        if (r.point_outside)
            outside_flag = 1'b1;
        if (r.corner_index != LAST_CORNER)
            return 1'b0;
        if (outside_flag) begin
            rsp.status = STATUS_OUTSIDE;
        end else begin
            rsp.vel_east  = sat32(acc_east);
            rsp.vel_north = sat32(acc_north);
            rsp.vel_up    = sat32(acc_up);
            rsp.status    = STATUS_OK;
        end
        acc_east     = '0;
        acc_north    = '0;
        acc_up       = '0;
        outside_flag = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Request construction
    // ------------------------------------------------------------------

    function automatic t_in_req mk_req(
        input logic [POS_W-1:0] pe, pn, pt,
        input logic [CORNER_W-1:0] idx,
        input logic signed [VAL_W-1:0] x, y, z,
        input logic is_null, outside
    );
        t_in_req r;
        r.pos_east      = pe;
        r.pos_north     = pn;
        r.pos_top       = pt;
        r.corner_index  = idx;
        r.comp_x_value  = x;
        r.comp_y_value  = y;
        r.comp_z_value  = z;
        r.value_is_null = is_null;
        r.point_outside = outside;
        return r;
    endfunction

    function automatic t_out_req mk_rsp(
        input logic signed [VAL_W-1:0] x, y, z,
        input logic st
    );
        t_out_req r;
        r.vel_east  = x;
        r.vel_north = y;
        r.vel_up    = z;
        r.status    = st;
        return r;
    endfunction

    task automatic add_row(input t_in_req r, input bit typed, input t_out_req rsp);
        t_corner_row row;
        row.req   = r;
        row.typed = typed;
        row.rsp   = rsp;
        directed_rows.push_back(row);
    endtask

    // positions: fully random, on a voxel centre, or at the fraction edges
    function automatic logic [POS_W-1:0] rand_pos();
        logic [POS_W-1:0] p;
        p = POS_W'($urandom);
        case ($urandom_range(0, 5))
            0: p[15:0] = 16'h8000;
            1: p[15:0] = 16'h0000;
            2: p[15:0] = 16'hFFFF;
            3: p[15:0] = 16'h7FFF;
            default: ;
        endcase
        return p;
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_val();
        case ($urandom_range(0, 9))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2, 3, 4: return VAL_W'(int'($urandom_range(0, 32'h3FFFF)) - 32'h20000);
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic t_in_req rand_corner(
        input logic [POS_W-1:0] pe, pn, pt,
        input logic [CORNER_W-1:0] idx
    );
        return mk_req(pe, pn, pt, idx, rand_val(), rand_val(), rand_val(),
                      $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 3);
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------

    // present one request, hold it through stalls, predict once it is taken
    task automatic send_req(input t_in_req r, input bit typed, input t_out_req typed_rsp);
        t_out_req rsp;
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
        req_count++;
        if (r.value_is_null)
            null_corners++;
        if (interp_corner(r, rsp))
            pending_vectors.push_back(typed ? typed_rsp : rsp);
    endtask

    // one point: seven corners in shuffled order, then the last corner
    task automatic send_cube();
        logic [POS_W-1:0]    pe, pn, pt;
        logic [CORNER_W-1:0] order[7];
        logic [CORNER_W-1:0] tmp;
        int k, j;
        pe = rand_pos();
        pn = rand_pos();
        pt = rand_pos();
        for (k = 0; k < 7; k++)
            order[k] = k[CORNER_W-1:0];
        for (k = 6; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (k = 0; k < 7; k++)
            send_req(rand_corner(pe, pn, pt, order[k]), 1'b0, '0);
        send_req(rand_corner(pe, pn, pt, LAST_CORNER), 1'b0, '0);
    endtask

    // broken set: a few random, possibly repeated corners, maybe closed
    task automatic send_noise();
        int k, n;
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
            send_req(rand_corner(rand_pos(), rand_pos(), rand_pos(),
                                 CORNER_W'($urandom_range(0, CORNERS - 2))), 1'b0, '0);
        if ($urandom_range(0, 1))
            send_req(rand_corner(rand_pos(), rand_pos(), rand_pos(), LAST_CORNER), 1'b0, '0);
    endtask

    // hold off new requests until every predicted vector has come back
    task automatic drain_vectors();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_vectors.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Response side: random stall, checker
    // ------------------------------------------------------------------

    always @(posedge i_clk)
        i_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : rsp_check
        t_out_req want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_vectors.size() == 0) begin
                $display("%0t: unexpected response, expected none, actual %h", $time, o_rsp);
                fail_count++;
            end else begin
                want = pending_vectors.pop_front();
                check_field("vel_east",  want.vel_east,  o_rsp.vel_east);
                check_field("vel_north", want.vel_north, o_rsp.vel_north);
                check_field("vel_up",    want.vel_up,    o_rsp.vel_up);
                check_field("status",    32'(want.status), 32'(o_rsp.status));
                vec_count++;
                if (o_rsp.status == STATUS_OUTSIDE)
                    outside_vecs++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin : stimulus
        int k;
        bit drained_mid;

        // on a voxel centre the whole weight lands on the lower corner
        add_row(mk_req(POS_CENTER, POS_CENTER, POS_CENTER, CORNER_ORIGIN,
                       32'sh00010000, -32'sh00010000, VAL_MAX, 1'b0, 1'b0), 1'b0, '0);
        add_row(mk_req(POS_CENTER, POS_CENTER, POS_CENTER, LAST_CORNER,
                       VAL_MIN, VAL_MAX, 32'sh12345678, 1'b0, 1'b0),
                1'b1, mk_rsp(32'sh00010000, -32'sh00010000, VAL_MAX, STATUS_OK));
        // outside point on a lone last corner
        add_row(mk_req(POS_MAX, POS_MAX, POS_MAX, LAST_CORNER,
                       VAL_MAX, VAL_MIN, -32'sd1, 1'b0, 1'b1),
                1'b1, mk_rsp('0, '0, '0, STATUS_OUTSIDE));
        // null corner counts as zero
        add_row(mk_req(POS_CENTER, POS_CENTER, POS_CENTER, CORNER_ORIGIN,
                       VAL_MAX, VAL_MAX, VAL_MAX, 1'b1, 1'b0), 1'b0, '0);
        add_row(mk_req(POS_CENTER, POS_CENTER, POS_CENTER, LAST_CORNER,
                       '0, '0, '0, 1'b0, 1'b0),
                1'b1, mk_rsp('0, '0, '0, STATUS_OK));
        // repeated corner pushes the sums past Q16.16: saturate both ways
        for (k = 0; k < 2; k++)
            add_row(mk_req(POS_CENTER, POS_CENTER, POS_CENTER, CORNER_ORIGIN,
                           VAL_MAX, VAL_MIN, '0, 1'b0, 1'b0), 1'b0, '0);
        add_row(mk_req(POS_CENTER, POS_CENTER, POS_CENTER, LAST_CORNER,
                       '0, '0, '0, 1'b0, 1'b0),
                1'b1, mk_rsp(VAL_MAX, VAL_MIN, '0, STATUS_OK));
        // full cube at the top of the position range
        for (k = 0; k < CORNERS; k++)
            add_row(mk_req(POS_MAX, POS_MAX, POS_MAX, k[CORNER_W-1:0],
                           VAL_W'(32'sh00100000 * (k + 1)), VAL_W'(-32'sh00030000 * k),
                           (k % 2) ? VAL_MAX : VAL_MIN, 1'b0, 1'b0), 1'b0, '0);
        // mostly zero position (fraction one half); corners in sparse order
        add_row(mk_req('0, '0, '0, CORNER_EAST, VAL_MAX, 32'sh00018000, -32'sd3,
                       1'b0, 1'b0), 1'b0, '0);
        add_row(mk_req('0, 24'h7FFFFF, '0, CORNER_NORTH, VAL_MIN, -32'sh00018000,
                       32'sd5, 1'b0, 1'b0), 1'b0, '0);
        add_row(mk_req('0, '0, 24'h00FFFF, CORNER_TOP, 32'sh0000FFFF, VAL_MAX,
                       VAL_MIN, 1'b0, 1'b0), 1'b0, '0);
        add_row(mk_req(24'h123456, '0, '0, LAST_CORNER, -32'sd1, 32'sd1, VAL_MAX,
                       1'b0, 1'b0), 1'b0, '0);
        // outside flag on an inner null corner sticks until the last corner
        add_row(mk_req(POS_CENTER, POS_MAX, '0, 3'd5, VAL_MAX, VAL_MAX, VAL_MAX,
                       1'b1, 1'b1), 1'b0, '0);
        add_row(mk_req(POS_CENTER, POS_MAX, '0, LAST_CORNER, VAL_MIN, VAL_MIN,
                       VAL_MIN, 1'b0, 1'b0),
                1'b1, mk_rsp('0, '0, '0, STATUS_OUTSIDE));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            send_req(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].rsp);
        drain_vectors();

        // random part: mostly whole cubes, some broken sets, a quiet window
        drained_mid = 1'b0;
        while (req_count < RAND_REQS + directed_rows.size()) begin
            idle_on = !(req_count > 450 && req_count < 800);
            if ($urandom_range(0, 99) < 85)
                send_cube();
            else
                send_noise();
            if (!drained_mid && req_count > 650) begin
                send_cube();
                drain_vectors();
                drained_mid = 1'b1;
            end
        end
        // close any open set so that no sum is left half built
        send_cube();
        idle_on = 1'b1;

        drain_vectors();
        repeat (TAIL_CYC) @(posedge i_clk);

        $display("covered %0d corner requests and %0d vectors, %0d outside, %0d null corners",
                 req_count, vec_count, outside_vecs, null_corners);
        if (fail_count == 0)
            $display("trilinear_vector_interpolator_core regression: pass");
        else
            $display("trilinear_vector_interpolator_core regression: fail");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("timeout with %0d vectors outstanding", pending_vectors.size());
        $display("trilinear_vector_interpolator_core regression: fail");
        $finish;
    end

endmodule
